>>> rtl/core/block_transfer_sequencer_defines.svh
// assertion macros for the block transfer sequencer
// each expects clk and arst_n in the scope where it is used
`ifndef BLOCK_TRANSFER_SEQUENCER_DEFINES_SVH
`define BLOCK_TRANSFER_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("block transfer sequencer check failed");

// next-cycle implication
`define BTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("block transfer sequencer check failed");

`else

`define BTS_ASSERT_NOW(label, ante, cons)
`define BTS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/bts_pkg.sv
package bts_pkg;

	localparam int NUM_REGS = 16;
	localparam int LIST_W = 16;
	localparam int CNT_W = $clog2(LIST_W + 1);
	localparam int IDX_W = 4;
	localparam int STEP_W = 3;

	localparam logic [LIST_W-1:0] REG_MASK = LIST_W'((33'd1 << NUM_REGS) - 33'd1);

	typedef enum logic [1:0] {
		ST_XFER  = 2'd0,
		ST_UNDEF = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [LIST_W-1:0] register_list;
		logic              pre_step;
		logic              step_up;
		logic              base_update;
		logic              is_load;
		logic              user_bank;
		logic [31:0]       base_value;
	} cmd_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] reg_index;
		logic [31:0]      mem_address;
		logic             load_dir;
		logic             wb_valid;
		logic [31:0]      wb_value;
		logic [1:0]       status;
		logic             last;
	} xfer_item_t;

	// datapath operations selected by the control word
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_COUNT,
		OP_NEWBASE,
		OP_START,
		OP_EMIT,
		OP_UNDEF,
		OP_EMPTY
	} dp_op_t;

	// jump conditions; when false the step counter moves on by one
	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_USR,
		JC_ZERO,
		JC_MORE
	} jcond_t;

	typedef struct packed {
		dp_op_t            op;
		jcond_t            cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	// program addresses
	localparam logic [STEP_W-1:0] PC_LOAD    = 3'd0;
	localparam logic [STEP_W-1:0] PC_COUNT   = 3'd1;
	localparam logic [STEP_W-1:0] PC_NEWBASE = 3'd2;
	localparam logic [STEP_W-1:0] PC_START   = 3'd3;
	localparam logic [STEP_W-1:0] PC_UNDEF   = 3'd4;
	localparam logic [STEP_W-1:0] PC_EMPTY   = 3'd5;
	localparam logic [STEP_W-1:0] PC_SPARE   = 3'd6;
	localparam logic [STEP_W-1:0] PC_EMIT    = 3'd7;

	// control store; the emit step sits at the top so that its fall-through wraps to load
	function automatic uword_t ucode_rom(input logic [STEP_W-1:0] pc);
		uword_t w;
		case (pc)
			PC_LOAD:    w = '{op: OP_LOAD,    cond: JC_NEXT,   target: PC_LOAD};
			PC_COUNT:   w = '{op: OP_COUNT,   cond: JC_USR,    target: PC_UNDEF};
			PC_NEWBASE: w = '{op: OP_NEWBASE, cond: JC_ZERO,   target: PC_EMPTY};
			PC_START:   w = '{op: OP_START,   cond: JC_ALWAYS, target: PC_EMIT};
			PC_UNDEF:   w = '{op: OP_UNDEF,   cond: JC_ALWAYS, target: PC_LOAD};
			PC_EMPTY:   w = '{op: OP_EMPTY,   cond: JC_ALWAYS, target: PC_LOAD};
			PC_EMIT:    w = '{op: OP_EMIT,    cond: JC_MORE,   target: PC_EMIT};
			default:    w = '{op: OP_NOP,     cond: JC_ALWAYS, target: PC_LOAD};
		endcase
		return w;
	endfunction

	function automatic logic [2:0] nibble_ones(input logic [3:0] n);
		return 3'(n[0]) + 3'(n[1]) + 3'(n[2]) + 3'(n[3]);
	endfunction

	function automatic logic [CNT_W-1:0] list_ones(input logic [LIST_W-1:0] l);
		logic [CNT_W-1:0] lo;
		logic [CNT_W-1:0] hi;
		lo = CNT_W'(nibble_ones(l[3:0])) + CNT_W'(nibble_ones(l[7:4]));
		hi = CNT_W'(nibble_ones(l[11:8])) + CNT_W'(nibble_ones(l[15:12]));
		return lo + hi;
	endfunction

	function automatic logic [IDX_W-1:0] lowest_set(input logic [LIST_W-1:0] l);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = LIST_W - 1; i >= 0; i--) begin
			if (l[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

>>> rtl/core/bts_if.sv
interface bts_cmd_if import bts_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bts_xfer_if import bts_pkg::*; ();
	logic       valid;
	logic       ready;
	xfer_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/block_transfer_sequencer.sv
// block transfer sequencer: expands one load/store multiple instruction into
// one beat per listed register, lowest register first, word addresses rising
// cmd channel: register list, mode bits, load and user-bank bits, base value
// xfer channel: register index, address, direction, base writeback, status, last
// an instruction with the user-bank bit gives one undefined beat; an empty
// list gives one empty beat; both carry last
// a small microprogram steps a plain datapath: load, count, new base, start
// address, then one emit step per transfer, looping on itself
// a command is taken only at the load step; an instruction of n registers then
// runs the count, new base and start steps and n emit steps (count then
// undefined for the user-bank case; count, new base then empty for an empty
// list); the first beat is registered by the first emit step
// results sit in one output register, which is refilled in the same cycle it is
// taken, so an instruction's transfers leave at one per cycle while the receiver keeps up
// when the receiver stalls, the emit step holds and nothing is lost; a new
// command can still be taken while the last beat of the previous one waits
// reset returns the step counter to load and empties the output register
`include "block_transfer_sequencer_defines.svh"

module block_transfer_sequencer import bts_pkg::*; (
	input logic clk,
	input logic arst_n,
	bts_cmd_if.sink cmd,
	bts_xfer_if.source xfer
);

	// step counter and current control word
	logic [STEP_W-1:0] upc_q;
	uword_t uw;

	// latched instruction
	logic [LIST_W-1:0] rem_q;
	logic              pre_q;
	logic              up_q;
	logic              wb_q;
	logic              ld_q;
	logic              usr_q;
	logic [31:0]       base_q;

	// address datapath
	logic [CNT_W-1:0]  count_q;
	logic [31:0]       newbase_q;
	logic [31:0]       addr_q;

	// output register
	xfer_item_t out_q;
	logic       out_valid_q;

	logic              slot_free;
	logic              fire;
	logic              take;
	logic              jump;
	logic [LIST_W-1:0] rem_next;
	logic              is_last;
	logic [31:0]       span;

	assign uw = ucode_rom(upc_q);

	// output slot can be refilled when empty or being emptied this cycle
	assign slot_free = !out_valid_q || xfer.ready;

	// drop the lowest set bit; the transfer is the last once nothing remains
	assign rem_next = rem_q & (rem_q - LIST_W'(1));
	assign is_last = (rem_next == '0);
	assign span = {25'd0, count_q, 2'b00};

	assign cmd.ready = (uw.op == OP_LOAD);
	assign take = cmd.valid && cmd.ready;

	// does the current step complete this cycle
	always_comb begin
		case (uw.op)
			OP_LOAD:  fire = cmd.valid;
			OP_EMIT:  fire = slot_free;
			OP_UNDEF: fire = slot_free;
			OP_EMPTY: fire = slot_free;
			default:  fire = 1'b1;
		endcase
	end

	always_comb begin
		case (uw.cond)
			JC_ALWAYS: jump = 1'b1;
			JC_USR:    jump = usr_q;
			JC_ZERO:   jump = (count_q == '0);
			JC_MORE:   jump = !is_last;
			default:   jump = 1'b0;
		endcase
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= PC_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				// fall-through from the emit step wraps round to load
				upc_q <= jump ? uw.target : upc_q + STEP_W'(1);
			end
			if (fire && (uw.op == OP_EMIT || uw.op == OP_UNDEF || uw.op == OP_EMPTY)) begin
				out_valid_q <= 1'b1;
			end else if (xfer.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (fire) begin
			case (uw.op)
				OP_LOAD: begin
					rem_q  <= cmd.data.register_list & REG_MASK;
					pre_q  <= cmd.data.pre_step;
					up_q   <= cmd.data.step_up;
					wb_q   <= cmd.data.base_update;
					ld_q   <= cmd.data.is_load;
					usr_q  <= cmd.data.user_bank;
					base_q <= cmd.data.base_value;
				end
				OP_COUNT: begin
					count_q <= list_ones(rem_q);
				end
				OP_NEWBASE: begin
					newbase_q <= up_q ? base_q + span : base_q - span;
				end
				OP_START: begin
					// ascending: base or base + 4; descending: new base or new base + 4
					if (up_q) begin
						addr_q <= pre_q ? base_q + 32'd4 : base_q;
					end else begin
						addr_q <= pre_q ? newbase_q : newbase_q + 32'd4;
					end
				end
				OP_EMIT: begin
					out_q.reg_index   <= lowest_set(rem_q);
					out_q.mem_address <= addr_q;
					out_q.load_dir    <= ld_q;
					out_q.wb_valid    <= is_last && wb_q;
					out_q.wb_value    <= (is_last && wb_q) ? newbase_q : 32'd0;
					out_q.status      <= ST_XFER;
					out_q.last        <= is_last;
					rem_q  <= rem_next;
					addr_q <= addr_q + 32'd4;
				end
				OP_UNDEF: begin
					out_q <= '{reg_index: '0, mem_address: '0, load_dir: 1'b0,
						wb_valid: 1'b0, wb_value: '0, status: ST_UNDEF, last: 1'b1};
				end
				OP_EMPTY: begin
					out_q <= '{reg_index: '0, mem_address: '0, load_dir: 1'b0,
						wb_valid: 1'b0, wb_value: '0, status: ST_EMPTY, last: 1'b1};
				end
				default: begin
				end
			endcase
		end
	end

	assign xfer.valid = out_valid_q;
	assign xfer.data = out_q;

	// checks
	`BTS_ASSERT_NEXT(a_cmd_then_count, take, upc_q == PC_COUNT)
	`BTS_ASSERT_NEXT(a_final_emit_returns, (uw.op == OP_EMIT) && fire && is_last, upc_q == PC_LOAD)
	`BTS_ASSERT_NOW(a_wb_only_on_last, xfer.valid && xfer.data.wb_valid, xfer.data.last)
	`BTS_ASSERT_NOW(a_flag_beats_last, xfer.valid && xfer.data.status != ST_XFER, xfer.data.last)

endmodule

>>> test/bts_xfer_checker.sv
`timescale 1ns / 1ps

// watches both channels, expands each accepted instruction into its transfers
// and compares every accepted xfer beat against the oldest one still due
module bts_xfer_checker import bts_pkg::*; (
	input logic clk,
	input logic arst_n,
	bts_cmd_if cmd,
	bts_xfer_if xfer,
	output int fail_count,
	output int outstanding,
	output int beats_checked
);

	xfer_item_t due_transfers[$];
	int errors = 0;
	int checked = 0;
	int due_count = 0;

	assign fail_count = errors;
	assign outstanding = due_count;
	assign beats_checked = checked;

	// all transfers one instruction should produce, in order
	function automatic void expand_instruction(input cmd_item_t c);
		xfer_item_t x;
		logic [LIST_W-1:0] regs;
		logic [31:0] span;
		logic [31:0] addr;
		logic [31:0] new_base;
		int n;
		int done;
		x = '0;
		done = 0;
		if (c.user_bank) begin
			x.status = ST_UNDEF;
			x.last = 1'b1;
			due_transfers.push_back(x);
			return;
		end
		regs = c.register_list & REG_MASK;
		n = $countones(regs);
		if (n == 0) begin
			x.status = ST_EMPTY;
			x.last = 1'b1;
			due_transfers.push_back(x);
			return;
		end
		span = 32'(4 * n);
		if (c.step_up) begin
			addr = c.pre_step ? c.base_value + 32'd4 : c.base_value;
			new_base = c.base_value + span;
		end else begin
			addr = c.pre_step ? c.base_value - span : c.base_value - span + 32'd4;
			new_base = c.base_value - span;
		end
		for (int i = 0; i < LIST_W; i++) begin
			if (regs[i]) begin
				done++;
				x = '0;
				x.reg_index = IDX_W'(i);
				x.mem_address = addr;
				x.load_dir = c.is_load;
				x.status = ST_XFER;
				if (done == n) begin
					x.last = 1'b1;
					x.wb_valid = c.base_update;
					x.wb_value = c.base_update ? new_base : 32'd0;
				end
				due_transfers.push_back(x);
				addr = addr + 32'd4;
			end
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		xfer_item_t want;
		xfer_item_t got;
		if (arst_n) begin
			// results first: a beat at this edge never belongs to a cmd taken at it
			if (xfer.valid === 1'b1 && xfer.ready === 1'b1) begin
				got = xfer.data;
				if (due_transfers.size() == 0) begin
					$error("unexpected xfer beat: reg_index %0d, address %0h",
						got.reg_index, got.mem_address);
					errors++;
				end else begin
					want = due_transfers.pop_front();
					check_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
					check_field("mem_address", want.mem_address, got.mem_address);
					check_field("load_dir", 32'(want.load_dir), 32'(got.load_dir));
					check_field("wb_valid", 32'(want.wb_valid), 32'(got.wb_valid));
					check_field("wb_value", want.wb_value, got.wb_value);
					check_field("status", 32'(want.status), 32'(got.status));
					check_field("last", 32'(want.last), 32'(got.last));
					checked++;
				end
			end
			if (cmd.valid === 1'b1 && cmd.ready === 1'b1) begin
				expand_instruction(cmd.data);
			end
			due_count = due_transfers.size();
		end
	end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

// drives load/store multiple instructions into the sequencer and leaves all
// prediction and comparison to the checker; this module only makes stimulus,
// paces both channels and gives the verdict
module tb;
	import bts_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 71;
	// a full list keeps the block busy the longest
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;

	// idle chances in percent, per cycle, for each side
	int cmd_idle_pct;
	int xfer_idle_pct;
	int instr_sent;
	int cycle_count;

	int fail_count;
	int outstanding;
	int beats_checked;

	bts_cmd_if cmd_ch ();
	bts_xfer_if xfer_ch ();

	block_transfer_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.xfer(xfer_ch)
	);

	bts_xfer_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.xfer(xfer_ch),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.beats_checked(beats_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver back-pressure, redrawn every falling edge
	initial begin
		xfer_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			xfer_ch.ready <= ($urandom_range(99) >= xfer_idle_pct);
		end
	end

	// overall watchdog
	initial begin
		cycle_count = 0;
		repeat (CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run timed out after %0d cycles", cycle_count);
		$display("status: fail");
		$finish;
	end

	function automatic cmd_item_t instr(input logic [15:0] list, input logic pre,
			input logic up, input logic wb, input logic ld, input logic usr,
			input logic [31:0] base);
		cmd_item_t c;
		c.register_list = list;
		c.pre_step = pre;
		c.step_up = up;
		c.base_update = wb;
		c.is_load = ld;
		c.user_bank = usr;
		c.base_value = base;
		return c;
	endfunction

	// one cmd beat; valid is only ever touched at a falling edge, once per edge,
	// so back-to-back beats keep it high without a dip
	task automatic send_instr(input cmd_item_t c);
		@(negedge clk);
		while ($urandom_range(99) < cmd_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		do begin
			@(posedge clk);
		end while (cmd_ch.ready !== 1'b1);
		instr_sent++;
	endtask

	initial begin
		cmd_item_t c;
		logic [15:0] list;
		logic [31:0] base;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		cmd_idle_pct = 17;
		xfer_idle_pct = 83;
		instr_sent = 0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty list, all four modes on a full list, wrap at both ends
		// of the address space, lowest and highest register alone, user bank
		send_instr(instr(16'h0000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_1000));
		send_instr(instr(16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_1000));
		send_instr(instr(16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0000_2000));
		send_instr(instr(16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 32'h0000_0000));
		send_instr(instr(16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0040));
		send_instr(instr(16'h0001, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFC));
		send_instr(instr(16'h8000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0000_0000));
		send_instr(instr(16'h8001, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF));
		send_instr(instr(16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 32'h1234_5678));
		send_instr(instr(16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF));
		send_instr(instr(16'h5555, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 32'h8000_0000));
		send_instr(instr(16'hAAAA, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'h7FFF_FFF0));
		send_instr(instr(16'h00F0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFF8));
		send_instr(instr(16'h0001, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 32'h0000_0000));
		send_instr(instr(16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000));
		send_instr(instr(16'h7FFE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF));

		// random part in three pacing phases: slow receiver, slow sender, none
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					cmd_idle_pct = 17;
					xfer_idle_pct = 83;
				end
				1: begin
					cmd_idle_pct = 83;
					xfer_idle_pct = 17;
				end
				default: begin
					cmd_idle_pct = 0;
					xfer_idle_pct = 0;
				end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				// spread of list shapes: empty, full, lone bit, sparse, dense
				case ($urandom_range(9))
					0: list = 16'h0000;
					1: list = 16'hFFFF;
					2: list = 16'h0001 << $urandom_range(15);
					3, 4: list = 16'($urandom & $urandom);
					default: list = 16'($urandom);
				endcase
				// bases near either end of memory catch wrap errors
				case ($urandom_range(7))
					0: base = 32'($urandom_range(63));
					1: base = 32'hFFFF_FFFF - 32'($urandom_range(63));
					default: base = $urandom;
				endcase
				c = instr(list, 1'($urandom), 1'($urandom), 1'($urandom),
					1'($urandom), ($urandom_range(9) == 0), base);
				send_instr(c);
			end
		end
		@(negedge clk);
		cmd_ch.valid <= 1'b0;

		// let every due transfer arrive, then give the block time to misbehave
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d instructions (all modes, empty and user-bank cases, address wrap)",
			instr_sent);
		$display("checked %0d transfer beats under three pacing phases, %0d mismatches",
			beats_checked, fail_count);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
